[hw/rtl/bpsc_pkg.sv]
// Shared types, constants and helpers for the balance PD / speed PI controller.
// No dependencies; imported by the top level, regs, multiplier and testbench.
`default_nettype none

package bpsc_pkg;

    // Serial multiplier geometry: multiplier bits consumed one per cycle
    localparam int MLW = 16;           // multiplier (gain) width
    localparam int MCW = 29;           // multiplicand width
    localparam int PW  = MCW + MLW;    // product width
    localparam int VW  = PW + 1;       // sum of two products
    localparam int QSH = 16;           // Q.16 -> integer
    localparam int HW  = VW - QSH;     // width after the final shift
    localparam int FSH = 8;            // Q.8 filter weight shift

    // Speed loop state widths
    localparam int FW = 28;            // filtered velocity, Q.8
    localparam int IW = 23;            // velocity integral, Q.8
    localparam int SW = 29;            // integral plus filter before clamp

    // Field widths
    localparam int DW   = 32;          // drive
    localparam int ANGW = 17;          // tilt angle and angle target
    localparam int GW   = 16;          // gyro, encoder counts, gains
    localparam int VTW  = 17;          // velocity target

    // Fixed constants
    localparam logic signed [VW-1:0] UP_OFFSET   = VW'(4000 * 65536);
    localparam logic signed [SW-1:0] INT_LIM     = SW'(8000 * 256);
    localparam logic signed [SW-1:0] NEG_INT_LIM = -SW'(8000 * 256);
    localparam logic [MLW-1:0]       FILT_NEW    = MLW'(77);
    localparam logic [MLW-1:0]       FILT_OLD    = MLW'(179);

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // Controller sequence
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_FIN1,
        ST_ACCUM,
        ST_CLAMP,
        ST_MUL2,
        ST_FIN2,
        ST_OUT
    } state_t;

    // Register map (word index)
    typedef enum logic [2:0] {
        REG_KP_UP   = 3'd0,
        REG_KD_UP   = 3'd1,
        REG_ANG_TGT = 3'd2,
        REG_KP_VEL  = 3'd3,
        REG_KI_VEL  = 3'd4,
        REG_VEL_TGT = 3'd5
    } reg_idx_t;

    // Loop selector
    localparam logic LOOP_UPRIGHT = 1'b0;
    localparam logic LOOP_SPEED   = 1'b1;

    typedef struct packed {
        logic [GW-1:0]   kp_up;
        logic [GW-1:0]   kd_up;
        logic [ANGW-1:0] ang_tgt;
        logic [GW-1:0]   kp_vel;
        logic [GW-1:0]   ki_vel;
        logic [VTW-1:0]  vel_tgt;
    } cfg_t;

    typedef struct packed {
        logic signed [MCW-1:0] mcand;
        logic signed [MLW-1:0] mplier;
    } mul_op_t;

    // Clamp a shifted result to the signed 32-bit range
    function automatic logic [DW-1:0] sat32(input logic signed [HW-1:0] x);
        logic signed [63:0] xe;
        xe = {{(64-HW){x[HW-1]}}, x};
        if (xe > MAX32) begin
            return MAX32[DW-1:0];
        end else if (xe < MIN32) begin
            return MIN32[DW-1:0];
        end
        return xe[DW-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/balance_pd_speed_pi_controller_top.sv]
// Top level of the balance PD / speed PI drive controller: sequencer and datapath.
// Depends on bpsc_pkg, bpsc_regs (configuration) and bpsc_smul (serial multipliers).
//
// Channel  Direction  Handshake           Payload (low bit first)
// s_*      in         s_tvalid/s_tready   tdata: tilt_angle, gyro_rate, left_count,
//                                          right_count; tuser: func
// m_*      out        m_tvalid/m_tready   tdata: drive, integral_clamped; tuser: loop_id
// p*       cfg        psel/penable        six registers at byte address 4*i
//
// Each pass runs two bit-serial multiplies side by side; an upright item makes one
// pass (MUL1, FIN1, OUT), a speed item two dependent passes (MUL1, FIN1, ACCUM,
// CLAMP, MUL2, FIN2, OUT), the second started once the clamped integral is ready.
// One item is worked at a time; a new item is taken while a finished result still
// waits in the output register, and a stalled result holds the block before output.
// Reset is synchronous, active low, and clears configuration and speed-loop state.
`default_nettype none

module balance_pd_speed_pi_controller_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // tilt_angle[16:0], gyro_rate[32:17],
                                        // left_count[48:33], right_count[64:49], zero pad
    input  wire logic [0:0]  s_tuser,   // func[0]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // drive[31:0], integral_clamped[32], zero pad
    output logic [0:0]       m_tuser,   // loop_id[0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bpsc_pkg::*;

    cfg_t cfg;

    bpsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack input fields
    logic            in_func;
    logic [ANGW-1:0] in_tilt;
    logic [GW-1:0]   in_gyro;
    logic [GW-1:0]   in_left;
    logic [GW-1:0]   in_right;

    assign in_func  = s_tuser[0];
    assign in_tilt  = s_tdata[16:0];
    assign in_gyro  = s_tdata[32:17];
    assign in_left  = s_tdata[48:33];
    assign in_right = s_tdata[64:49];

    state_t state_reg, state_next;

    logic                 func_reg, func_next;
    logic signed [FW-1:0] filt_reg, filt_next;
    logic signed [IW-1:0] integ_reg, integ_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic                 hit_reg, hit_next;
    logic signed [VW-1:0] v_reg, v_next;
    logic                 m_valid_reg, m_valid_next;
    logic [39:0]          m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    // FSM outputs
    logic accept;
    logic mul_start;
    logic ld_fin1;
    logic ld_sum;
    logic ld_integ;
    logic ld_fin2;
    logic out_load;
    logic out_free;

    mul_op_t              op_a, op_b;
    logic                 done_a, done_b;
    logic signed [PW-1:0] prod_a, prod_b;

    bpsc_smul u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op      (op_a),
        .done    (done_a),
        .prod    (prod_a)
    );

    bpsc_smul u_mul_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op      (op_b),
        .done    (done_b),
        .prod    (prod_b)
    );

    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MUL1;
            ST_MUL1:  if (done_a && done_b) state_next = ST_FIN1;
            ST_FIN1:  state_next = (func_reg == LOOP_SPEED) ? ST_ACCUM : ST_OUT;
            ST_ACCUM: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MUL2;
            ST_MUL2:  if (done_a && done_b) state_next = ST_FIN2;
            ST_FIN2:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        ld_fin1   = 1'b0;
        ld_sum    = 1'b0;
        ld_integ  = 1'b0;
        ld_fin2   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_FIN1:  ld_fin1 = 1'b1;
            ST_ACCUM: ld_sum = 1'b1;
            ST_CLAMP: begin
                ld_integ  = 1'b1;
                mul_start = 1'b1;
            end
            ST_FIN2:  ld_fin2 = 1'b1;
            ST_OUT:   out_load = out_free;
            default:  s_tready = 1'b0;
        endcase
        accept = s_tvalid & s_tready;
        if (accept) begin
            mul_start = 1'b1;
        end
    end

    // Operand preparation
    logic signed [ANGW:0]  err;
    logic signed [18:0]    spd;
    logic signed [SW-1:0]  integ_clamp;
    logic                  integ_hit;

    assign err = {in_tilt[ANGW-1], in_tilt} - {cfg.ang_tgt[ANGW-1], cfg.ang_tgt};
    assign spd = {{3{in_left[GW-1]}}, in_left} + {{3{in_right[GW-1]}}, in_right}
               - {{2{cfg.vel_tgt[VTW-1]}}, cfg.vel_tgt};

    // Clamp the accumulated integral to the symmetric limit
    always_comb begin
        if (sum_reg > INT_LIM) begin
            integ_clamp = INT_LIM;
        end else if (sum_reg < NEG_INT_LIM) begin
            integ_clamp = NEG_INT_LIM;
        end else begin
            integ_clamp = sum_reg;
        end
        integ_hit = (integ_clamp == INT_LIM) || (integ_clamp == NEG_INT_LIM);
    end

    // Select multiplier operands: first pass at accept, second pass at clamp
    always_comb begin
        if (state_reg == ST_CLAMP) begin
            op_a.mcand  = {{(MCW-FW){filt_reg[FW-1]}}, filt_reg};
            op_a.mplier = cfg.kp_vel;
            op_b.mcand  = {{(MCW-IW){integ_clamp[IW-1]}}, integ_clamp[IW-1:0]};
            op_b.mplier = cfg.ki_vel;
        end else if (in_func == LOOP_UPRIGHT) begin
            op_a.mcand  = {{(MCW-ANGW-1){err[ANGW]}}, err};
            op_a.mplier = cfg.kp_up;
            op_b.mcand  = {{(MCW-GW){in_gyro[GW-1]}}, in_gyro};
            op_b.mplier = cfg.kd_up;
        end else begin
            op_a.mcand  = {{(MCW-FW){filt_reg[FW-1]}}, filt_reg};
            op_a.mplier = FILT_OLD;
            op_b.mcand  = {{(MCW-19){spd[18]}}, spd};
            op_b.mplier = FILT_NEW;
        end
    end

    // Datapath register updates
    logic signed [PW-1:0] prod_a_shr;
    logic signed [VW-1:0] prod_a_x, prod_b_x;
    logic signed [VW-1:0] v_off, v_shr;

    assign prod_a_shr = prod_a >>> FSH;
    assign prod_a_x   = {{(VW-PW){prod_a[PW-1]}}, prod_a};
    assign prod_b_x   = {{(VW-PW){prod_b[PW-1]}}, prod_b};

    // Push the upright drive away from zero, then floor to integer
    always_comb begin
        if (func_reg == LOOP_SPEED) begin
            v_off = v_reg;
        end else if (v_reg[VW-1]) begin
            v_off = v_reg - UP_OFFSET;
        end else begin
            v_off = v_reg + UP_OFFSET;
        end
        v_shr = v_off >>> QSH;
    end

    always_comb begin
        func_next    = func_reg;
        filt_next    = filt_reg;
        integ_next   = integ_reg;
        sum_next     = sum_reg;
        hit_next     = hit_reg;
        v_next       = v_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (accept) begin
            func_next = in_func;
        end
        // Upright: form P - D in Q.16; speed: new filter value
        if (ld_fin1) begin
            if (func_reg == LOOP_SPEED) begin
                filt_next = prod_b[FW-1:0] + prod_a_shr[FW-1:0];
            end else begin
                v_next = prod_a_x - (prod_b_x <<< FSH);
                hit_next = 1'b0;
            end
        end
        if (ld_sum) begin
            sum_next = {{(SW-IW){integ_reg[IW-1]}}, integ_reg}
                     + {{(SW-FW){filt_reg[FW-1]}}, filt_reg};
        end
        if (ld_integ) begin
            integ_next = integ_clamp[IW-1:0];
            hit_next   = integ_hit;
        end
        if (ld_fin2) begin
            v_next = prod_a_x + prod_b_x;
        end
        // Output register: hold while stalled, release on transfer
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, hit_reg, sat32(v_shr[HW-1:0])};
            m_user_next  = func_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filt_reg    <= '0;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filt_reg    <= filt_next;
            integ_reg   <= integ_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg   <= func_next;
        sum_reg    <= sum_next;
        hit_reg    <= hit_next;
        v_reg      <= v_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

`default_nettype wire

[hw/rtl/bpsc_regs.sv]
// Configuration register file with a simple APB-style write/read port.
// Depends on bpsc_pkg for the register map and the cfg_t bundle.
`default_nettype none

module bpsc_regs (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output bpsc_pkg::cfg_t           cfg
);
    import bpsc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    // Decode the write into the addressed register; drop unmapped indexes
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_KP_UP:   cfg_next.kp_up   = pwdata[GW-1:0];
                REG_KD_UP:   cfg_next.kd_up   = pwdata[GW-1:0];
                REG_ANG_TGT: cfg_next.ang_tgt = pwdata[ANGW-1:0];
                REG_KP_VEL:  cfg_next.kp_vel  = pwdata[GW-1:0];
                REG_KI_VEL:  cfg_next.ki_vel  = pwdata[GW-1:0];
                REG_VEL_TGT: cfg_next.vel_tgt = pwdata[VTW-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the raw register bits
    always_comb begin
        case (idx)
            REG_KP_UP:   prdata = {{(32-GW){1'b0}}, cfg_reg.kp_up};
            REG_KD_UP:   prdata = {{(32-GW){1'b0}}, cfg_reg.kd_up};
            REG_ANG_TGT: prdata = {{(32-ANGW){1'b0}}, cfg_reg.ang_tgt};
            REG_KP_VEL:  prdata = {{(32-GW){1'b0}}, cfg_reg.kp_vel};
            REG_KI_VEL:  prdata = {{(32-GW){1'b0}}, cfg_reg.ki_vel};
            REG_VEL_TGT: prdata = {{(32-VTW){1'b0}}, cfg_reg.vel_tgt};
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bpsc_smul.sv]
// Serial-parallel signed multiplier: one multiplier bit per cycle.
// Depends on bpsc_pkg for widths and the mul_op_t operand bundle.
`default_nettype none

module bpsc_smul (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire bpsc_pkg::mul_op_t        op,
    output logic                          done,
    output logic signed [bpsc_pkg::PW-1:0] prod
);
    import bpsc_pkg::*;

    localparam int CW = $clog2(MLW);
    localparam logic [CW-1:0] LAST = CW'(MLW - 1);

    logic signed [PW-1:0]  mcand_reg, mcand_next;
    logic        [MLW-1:0] mplier_reg, mplier_next;
    logic signed [PW-1:0]  acc_reg, acc_next;
    logic        [CW-1:0]  cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic signed [PW-1:0]  pp;

    assign done = done_reg;
    assign prod = acc_reg;
    assign pp   = mplier_reg[0] ? mcand_reg : '0;

    // Load on start, then add one shifted partial product per cycle;
    // the sign bit of the multiplier carries negative weight
    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = {{(PW-MCW){op.mcand[MCW-1]}}, op.mcand};
            mplier_next = op.mplier;
            acc_next    = '0;
            cnt_next    = '0;
            run_next    = 1'b1;
        end else if (run_reg) begin
            acc_next    = (cnt_reg == LAST) ? acc_reg - pp : acc_reg + pp;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

endmodule

`default_nettype wire

[hw/rtl/bpsc_checker.sv]
// Port-level checks for the balance PD / speed PI controller, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module bpsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Upright results never flag the integral clamp
    a_up_noclamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == 1'b0) |-> !m_tdata[32])
        else $error("clamp flag on upright result");

    // Upright drive is pushed outside the dead band around zero
    a_up_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == 1'b0) |->
            ($signed(m_tdata[31:0]) >= 32'sd4000) || ($signed(m_tdata[31:0]) <= -32'sd4001))
        else $error("upright drive inside dead band");

    // Reset empties the output register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind balance_pd_speed_pi_controller_top bpsc_checker u_bpsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[verif/tb_balance_pd_speed_pi_controller_top.sv]
// Testbench for balance_pd_speed_pi_controller_top: directed and random control items,
// APB register setup, and a built-in model of both loops that checks every result.
// Depends on bpsc_pkg and the controller RTL.

module tb_balance_pd_speed_pi_controller_top;
    import bpsc_pkg::*;

    // Spare register slots that the block must ignore
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Fixed-point constants of the two loops
    localparam longint UPRIGHT_BIAS = longint'(4000) * 65536;
    localparam longint INTEG_LIMIT  = longint'(8000) * 256;
    localparam longint FILT_W_NEW   = 77;
    localparam longint FILT_W_OLD   = 179;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        logic               func;
        logic signed [16:0] tilt;
        logic signed [15:0] gyro;
        logic signed [15:0] left_cnt;
        logic signed [15:0] right_cnt;
    } ctl_item_t;

    typedef struct {
        logic        loop_id;
        logic [31:0] drive;
        logic        clamped;
    } drive_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model copy of configuration and speed-loop state
    logic signed [15:0] kp_up_q   = '0;
    logic signed [15:0] kd_up_q   = '0;
    logic signed [16:0] ang_tgt_q = '0;
    logic signed [15:0] kp_vel_q  = '0;
    logic signed [15:0] ki_vel_q  = '0;
    logic signed [16:0] vel_tgt_q = '0;
    longint             speed_filt  = 0;
    longint             speed_integ = 0;

    drive_res_t pending_drives[$];
    int         errors      = 0;
    bit         tx_bursty   = 1'b1;
    int         burst_left  = 0;
    rx_mode_t   rx_mode     = RX_ALWAYS;
    int         rx_hold     = 0;
    int         rx_tick     = 0;

    balance_pd_speed_pi_controller_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // tilt_angle, gyro_rate, left_count, right_count, zero pad
        .s_tuser  (s_tuser),    // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // drive, integral_clamped, zero pad
        .m_tuser  (m_tuser),    // loop_id
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] clip_to_int32(input longint x);
        if (x > longint'(32'sh7fffffff)) begin
            return 32'h7fffffff;
        end else if (x < -longint'(32'sh7fffffff) - 1) begin
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    // Run one item through its loop; speed items advance the speed state
    function automatic drive_res_t step_controller(input ctl_item_t it);
        drive_res_t r;
        longint     err;
        longint     acc;
        longint     now;
        longint     filt;
        longint     integ;
        r.loop_id = it.func;
        r.clamped = 1'b0;
        if (it.func == LOOP_UPRIGHT) begin
            err = longint'(it.tilt) - longint'(ang_tgt_q);
            acc = longint'(kp_up_q) * err - longint'(kd_up_q) * longint'(it.gyro) * 256;
            acc = (acc >= 0) ? acc + UPRIGHT_BIAS : acc - UPRIGHT_BIAS;
            r.drive = clip_to_int32(acc >>> 16);
        end else begin
            now = (longint'(it.left_cnt) + longint'(it.right_cnt) - longint'(vel_tgt_q)) * 256;
            filt = (FILT_W_NEW * now + FILT_W_OLD * speed_filt) >>> 8;
            integ = speed_integ + filt;
            if (integ > INTEG_LIMIT) begin
                integ = INTEG_LIMIT;
            end
            if (integ < -INTEG_LIMIT) begin
                integ = -INTEG_LIMIT;
            end
            speed_filt = filt;
            speed_integ = integ;
            r.clamped = (integ == INTEG_LIMIT) || (integ == -INTEG_LIMIT);
            acc = filt * longint'(kp_vel_q) + integ * longint'(ki_vel_q);
            r.drive = clip_to_int32(acc >>> 16);
        end
        return r;
    endfunction

    function automatic ctl_item_t mk_item(input logic func, input int tilt, input int gyro,
                                          input int left_cnt, input int right_cnt);
        ctl_item_t it;
        it.func = func;
        it.tilt = 17'(tilt);
        it.gyro = 16'(gyro);
        it.left_cnt = 16'(left_cnt);
        it.right_cnt = 16'(right_cnt);
        return it;
    endfunction

    // Uniform value with extra weight on both ends
    function automatic int pick(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic ctl_item_t rand_item();
        int cmax;
        cmax = ($urandom_range(0, 1) == 0) ? 300 : 32767;
        return mk_item(1'($urandom_range(0, 1)), pick(-46080, 46080), pick(-32768, 32767),
                       pick(-cmax - 1, cmax), pick(-cmax - 1, cmax));
    endfunction

    // Offer one item, with random gaps between bursts when tx_bursty is set, and record its result
    task automatic send_item(input ctl_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (tx_bursty && gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.right_cnt, it.left_cnt, it.gyro, it.tilt};
        s_tuser  <= it.func;
        do @(posedge aclk); while (!s_tready);
        pending_drives.push_back(step_controller(it));
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        logic [31:0] word;
        word = value;
        // scramble the bits above the widest register now and then
        if ($urandom_range(0, 1) == 1) begin
            word[31:17] = 15'($urandom);
        end
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_KP_UP:   kp_up_q   = word[15:0];
            REG_KD_UP:   kd_up_q   = word[15:0];
            REG_ANG_TGT: ang_tgt_q = word[16:0];
            REG_KP_VEL:  kp_vel_q  = word[15:0];
            REG_KI_VEL:  ki_vel_q  = word[15:0];
            REG_VEL_TGT: vel_tgt_q = word[16:0];
            default: ;
        endcase
    endtask

    task automatic write_upright(input int kp, input int kd, input int ang);
        write_reg(REG_KP_UP, kp);
        write_reg(REG_KD_UP, kd);
        write_reg(REG_ANG_TGT, ang);
    endtask

    task automatic write_speed(input int kp, input int ki, input int vt);
        write_reg(REG_KP_VEL, kp);
        write_reg(REG_KI_VEL, ki);
        write_reg(REG_VEL_TGT, vt);
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        drive_res_t want;
        if (pending_drives.size() == 0) begin
            $display("%0t: unexpected result: loop_id %0d drive %0d", $time, m_tuser[0],
                     $signed(m_tdata[31:0]));
            errors++;
            return;
        end
        want = pending_drives.pop_front();
        if (m_tuser[0] !== want.loop_id) begin
            $display("%0t: loop_id expected %0d got %0d", $time, want.loop_id, m_tuser[0]);
            errors++;
        end
        if (m_tdata[31:0] !== want.drive) begin
            $display("%0t: drive expected %0d got %0d", $time, $signed(want.drive),
                     $signed(m_tdata[31:0]));
            errors++;
        end
        if (m_tdata[32] !== want.clamped) begin
            $display("%0t: integral_clamped expected %0d got %0d", $time, want.clamped,
                     m_tdata[32]);
            errors++;
        end
        if (m_tdata[39:33] !== 7'b0) begin
            $display("%0t: tdata pad expected 0 got %h", $time, m_tdata[39:33]);
            errors++;
        end
    endtask

    // Result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result();
        end
        rx_tick++;
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
                default:   m_tready <= ((rx_tick % 9) < 6);
            endcase
        end
    end

    // Zero gains after reset: upright gives the bare offset, speed state still moves
    task automatic test_reset_state();
        send_item(mk_item(LOOP_UPRIGHT, 46080, -32768, 5, -5));
        send_item(mk_item(LOOP_UPRIGHT, -46080, 32767, 0, 0));
        send_item(mk_item(LOOP_SPEED, 1, 2, 32767, 32767));
        send_item(mk_item(LOOP_SPEED, -3, -4, -32768, -32768));
        wait_idle();
    endtask

    // Upright loop extremes and the sign boundary of the offset
    task automatic test_upright_loop();
        write_upright(32767, -32768, -46080);
        send_item(mk_item(LOOP_UPRIGHT, 46080, 32767, 32767, -32768));
        send_item(mk_item(LOOP_UPRIGHT, -46080, 0, 0, 0));
        wait_idle();
        write_upright(-32768, 32767, 46080);
        send_item(mk_item(LOOP_UPRIGHT, -46080, 32767, 0, 0));
        send_item(mk_item(LOOP_UPRIGHT, 46080, -32768, 0, 0));
        wait_idle();
        // just below, just above and at zero before the offset
        write_upright(0, 1, 0);
        send_item(mk_item(LOOP_UPRIGHT, 0, 1, 0, 0));
        send_item(mk_item(LOOP_UPRIGHT, 0, -1, 0, 0));
        send_item(mk_item(LOOP_UPRIGHT, 0, 0, 0, 0));
        wait_idle();
        write_upright(1, 0, 0);
        send_item(mk_item(LOOP_UPRIGHT, -1, 0, 0, 0));
        wait_idle();
    endtask

    // Speed loop: drive the integral into both limits, then let it decay
    task automatic test_speed_loop();
        write_speed(32767, 32767, -65536);
        send_item(mk_item(LOOP_SPEED, 0, 0, 32767, 32767));
        send_item(mk_item(LOOP_SPEED, 46080, -32768, 32767, 32767));
        send_item(mk_item(LOOP_UPRIGHT, 100, 200, -32768, 32767));
        send_item(mk_item(LOOP_SPEED, 0, 0, 32767, 32767));
        wait_idle();
        write_speed(-32768, -32768, 65535);
        send_item(mk_item(LOOP_SPEED, 0, 0, -32768, -32768));
        send_item(mk_item(LOOP_SPEED, 0, 0, -32768, -32768));
        send_item(mk_item(LOOP_SPEED, -46080, 32767, -32768, -32768));
        wait_idle();
        write_speed(256, 256, 0);
        send_item(mk_item(LOOP_SPEED, 0, 0, 0, 0));
        send_item(mk_item(LOOP_SPEED, 0, 0, 0, 0));
        send_item(mk_item(LOOP_SPEED, 0, 0, 1, -1));
        wait_idle();
    endtask

    // Writes to the unused slots must leave every register alone
    task automatic test_spare_registers();
        write_reg(REG_SPARE_LO, int'($urandom));
        write_reg(REG_SPARE_HI, int'($urandom));
        repeat (4) @(posedge aclk);
    endtask

    // Random items under several register settings and idling styles
    task automatic test_random_mix();
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_upright(32767, 32767, 46080);
                    write_speed(32767, 32767, 65535);
                end
                1: begin
                    write_upright(-32768, -32768, -46080);
                    write_speed(-32768, -32768, -65536);
                end
                2: begin
                    write_upright(pick(-512, 512), pick(-512, 512), pick(-2560, 2560));
                    write_speed(pick(-512, 512), pick(-64, 64), pick(-100, 100));
                end
                default: begin
                    write_upright(pick(-32768, 32767), pick(-32768, 32767),
                                  pick(-46080, 46080));
                    write_speed(pick(-32768, 32767), pick(-32768, 32767),
                                pick(-65536, 65535));
                end
            endcase
            tx_bursty = (ph != 0);
            case (ph % 3)
                0: rx_mode = RX_ALWAYS;
                1: rx_mode = RX_RANDOM;
                default: rx_mode = RX_PATTERN;
            endcase
            repeat (100) send_item(rand_item());
        end
        wait_idle();
    endtask

    // Hold the result side off while items keep coming, so the input stalls
    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_mode = RX_RANDOM;
        rx_hold = 300;
        repeat (24) send_item(rand_item());
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_upright_loop();
        test_speed_loop();
        test_spare_registers();
        test_random_mix();
        test_backpressure();
        if (errors == 0 && pending_drives.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
